### src/akfw_pkg.sv
// ============================================================================
// akfw_pkg
// Shared types and constants for the front-wheel kinematics pipeline.
// ============================================================================
package akfw_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_WHEEL_TRACK = 2'd0,
    CFG_WHEEL_BASE  = 2'd1,
    CFG_STEP_RELOAD = 2'd2
  } akfw_cfg_idx_e;

  localparam logic [11:0] TRACK_RESET  = 12'd500;
  localparam logic [11:0] BASE_RESET   = 12'd600;
  localparam logic [15:0] RELOAD_RESET = 16'd1049;

  // Pipeline depths.
  localparam int SQRT_STAGES   = 32;
  localparam int DIV_STAGES    = 25;
  localparam int LAT_SPEED     = 1 + SQRT_STAGES + 1 + DIV_STAGES;
  localparam int CORDIC_ITERS  = 30;
  localparam int LAT_STEER     = 1 + CORDIC_ITERS + 3;
  localparam int STEER_ALIGN   = LAT_SPEED - LAT_STEER;

  localparam logic [30:0] QUARTER_TURN = 31'h4000_0000;
  localparam logic [8:0]  STEPS_MAX    = 9'd511;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic [29:0] ATAN_TURNS [CORDIC_ITERS] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
    30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
    30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
    30'd20, 30'd10, 30'd5, 30'd3, 30'd1
  };

  typedef struct packed {
    logic signed [20:0] turn_radius;
    logic signed [15:0] rear_speed;
  } akfw_cmd_t;

  typedef struct packed {
    logic signed [23:0] left_speed;
    logic signed [23:0] right_speed;
    logic [8:0]         left_steer_steps;
    logic [8:0]         right_steer_steps;
    logic [15:0]        step_reload;
    logic               zero_radius;
  } akfw_res_t;

  // Per-item flags that travel alongside the arithmetic lanes.
  typedef struct packed {
    logic        neg;
    logic        zero;
    logic [15:0] reload;
  } akfw_side_t;

endpackage

### src/akfw_stream_if.sv
// ============================================================================
// akfw_stream_if
// Valid/ready stream channel carrying one payload per beat.
// ============================================================================
interface akfw_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### src/akfw_isqrt.sv
// ============================================================================
// akfw_isqrt
// Pipelined integer square root, one result bit per stage.
// ============================================================================
module akfw_isqrt
  import akfw_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] x_i,
  output logic [31:0] root_o
);

  logic [63:0] rem_q  [SQRT_STAGES];
  logic [31:0] root_q [SQRT_STAGES];

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
    localparam int K = SQRT_STAGES - 1 - j;
    logic [63:0] rem_in;
    logic [31:0] root_in;
    logic [64:0] trial;
    logic        take;

    if (j == 0) begin : g_first
      assign rem_in  = x_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    // (q + 2^K)^2 - q^2; the bits of q sit above K, so OR acts as add.
    assign trial = ({33'd0, root_in} << (K + 1)) | (65'd1 << (2 * K));
    assign take  = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= take ? rem_in - trial[63:0] : rem_in;
        root_q[j] <= take ? (root_in | (32'd1 << K)) : root_in;
      end
    end
  end

  assign root_o = root_q[SQRT_STAGES-1];

endmodule

### src/akfw_div.sv
// ============================================================================
// akfw_div
// Pipelined restoring divider with a 24-bit quotient and overflow flag.
// ============================================================================
module akfw_div
  import akfw_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [36:0] num_i,
  input  logic [20:0] den_i,
  output logic [23:0] quo_o,
  output logic        ovf_o
);

  localparam int QBITS = DIV_STAGES - 1;

  logic [36:0] rem_q [DIV_STAGES];
  logic [20:0] den_q [DIV_STAGES];
  logic [23:0] quo_q [DIV_STAGES];
  logic        ovf_q [DIV_STAGES];

  // First stage: flag quotients of 2^24 or more.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= {8'd0, num_i[36:24]} >= den_i;
    end
  end

  for (genvar j = 0; j < QBITS; j++) begin : g_stage
    localparam int K = QBITS - 1 - j;
    logic [44:0] sub;
    logic        take;

    assign sub  = {24'd0, den_q[j]} << K;
    assign take = {8'd0, rem_q[j]} >= sub;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= take ? rem_q[j] - sub[36:0] : rem_q[j];
        quo_q[j+1] <= take ? (quo_q[j] | (24'd1 << K)) : quo_q[j];
        den_q[j+1] <= den_q[j];
        ovf_q[j+1] <= ovf_q[j];
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];
  assign ovf_o = ovf_q[DIV_STAGES-1];

endmodule

### src/akfw_speed_lane.sv
// ============================================================================
// akfw_speed_lane
// Wheel radius, product with rear speed and division by the turn radius.
// ============================================================================
module akfw_speed_lane
  import akfw_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [21:0] abs_off_i,
  input  logic [11:0] base_i,
  input  logic [15:0] abs_speed_i,
  input  logic [20:0] abs_radius_i,
  output logic [23:0] mag_o,
  output logic        ovf_o
);

  localparam int SPD_DLY = 1 + SQRT_STAGES;
  localparam int RAD_DLY = SPD_DLY + 1;

  logic [43:0] off_sq;
  logic [23:0] base_sq;
  logic [43:0] sum_q;
  logic [31:0] root;
  logic [15:0] spd_q [SPD_DLY];
  logic [20:0] rad_q [RAD_DLY];
  logic [47:0] prod;
  logic [36:0] num_q;

  // Squared doubled wheel radius.
  assign off_sq  = abs_off_i * abs_off_i;
  assign base_sq = base_i * base_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= off_sq + {18'd0, base_sq, 2'b00};
    end
  end

  akfw_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .x_i    ({sum_q, 20'd0}),
    .root_o (root)
  );

  // Operands wait for the root.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      spd_q[0] <= abs_speed_i;
      rad_q[0] <= abs_radius_i;
      for (int i = 1; i < SPD_DLY; i++) spd_q[i] <= spd_q[i-1];
      for (int i = 1; i < RAD_DLY; i++) rad_q[i] <= rad_q[i-1];
    end
  end

  assign prod = root * spd_q[SPD_DLY-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= prod[47:11];
    end
  end

  akfw_div u_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (num_q),
    .den_i (rad_q[RAD_DLY-1]),
    .quo_o (mag_o),
    .ovf_o (ovf_o)
  );

endmodule

### src/akfw_cordic.sv
// ============================================================================
// akfw_cordic
// Pipelined CORDIC vectoring that turns a wheel geometry into stepper steps.
// ============================================================================
module akfw_cordic
  import akfw_pkg::*;
#(
  parameter int unsigned STEPS_PER_REV = 2000
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [21:0] abs_off_i,
  input  logic [11:0] base_i,
  output logic [8:0]  steps_o
);

  localparam logic [15:0] STEPS = 16'(STEPS_PER_REV);

  logic signed [40:0] x_q [CORDIC_ITERS+1];
  logic signed [40:0] y_q [CORDIC_ITERS+1];
  logic signed [32:0] z_q [CORDIC_ITERS+1];
  logic               bz_q [CORDIC_ITERS+1];
  logic               oz_q [CORDIC_ITERS+1];
  logic [30:0]        ang_d, ang_q;
  logic [46:0]        prod_q;
  logic [8:0]         steps_q;

  // Load the vector.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]  <= $signed({3'd0, abs_off_i, 16'd0});
      y_q[0]  <= $signed({12'd0, base_i, 17'd0});
      z_q[0]  <= '0;
      bz_q[0] <= base_i == '0;
      oz_q[0] <= abs_off_i == '0;
    end
  end

  for (genvar j = 0; j < CORDIC_ITERS; j++) begin : g_iter
    logic signed [40:0] xs, ys;
    logic signed [32:0] at;
    assign xs = x_q[j] >>> j;
    assign ys = y_q[j] >>> j;
    assign at = $signed({3'd0, ATAN_TURNS[j]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[j] > 0) begin
          x_q[j+1] <= x_q[j] + ys;
          y_q[j+1] <= y_q[j] - xs;
          z_q[j+1] <= z_q[j] + at;
        end else begin
          x_q[j+1] <= x_q[j] - ys;
          y_q[j+1] <= y_q[j] + xs;
          z_q[j+1] <= z_q[j] - at;
        end
        bz_q[j+1] <= bz_q[j];
        oz_q[j+1] <= oz_q[j];
      end
    end
  end

  // Special geometries and clamping to a quarter turn.
  always_comb begin
    if (bz_q[CORDIC_ITERS]) begin
      ang_d = '0;
    end else if (oz_q[CORDIC_ITERS]) begin
      ang_d = QUARTER_TURN;
    end else if (z_q[CORDIC_ITERS][32]) begin
      ang_d = '0;
    end else if (z_q[CORDIC_ITERS] > $signed({2'b00, QUARTER_TURN})) begin
      ang_d = QUARTER_TURN;
    end else begin
      ang_d = z_q[CORDIC_ITERS][30:0];
    end
  end

  // Scale to steps and saturate.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q   <= ang_d;
      prod_q  <= ang_q * STEPS;
      steps_q <= (prod_q[46:41] != '0) ? STEPS_MAX : prod_q[40:32];
    end
  end

  assign steps_o = steps_q;

endmodule

### src/ackermann_front_wheel_kinematics.sv
// ============================================================================
// ackermann_front_wheel_kinematics
// Front hub speeds and steering steps from a rear-axle turn command.
// ============================================================================
// Usage:
//   cmd_i carries one beat per command (turn radius in mm, rear speed in
//   mm/s); res_o returns one beat per command with both front hub speeds,
//   both steering step counts, the stepper reload value and the zero-radius
//   flag. Results leave in command order.
//   The result path runs through the 32-stage square root and the
//   25-stage divider in each speed lane. One command is accepted per
//   cycle while the output buffer is not full. The configuration port
//   writes wheel track, wheel base and reload value by index; the user must
//   write it only while no commands are in flight; the block does not
//   enforce this. Reset clears all valid flags and the output buffer and
//   loads the default geometry. When the receiver stalls, a two-beat output
//   buffer absorbs results; once both entries are full the whole pipeline
//   holds and cmd_i.ready drops, without losing or repeating any beat.
// ============================================================================
module ackermann_front_wheel_kinematics
  import akfw_pkg::*;
#(
  parameter int unsigned STEPS_PER_REV = 2000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  akfw_stream_if.sink   cmd_i,
  akfw_stream_if.source res_o
);

  logic [11:0] track_q, base_q;
  logic [15:0] reload_q;
  logic        en;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q  <= TRACK_RESET;
      base_q   <= BASE_RESET;
      reload_q <= RELOAD_RESET;
    end else if (cfg_we_i) begin
      case (akfw_cfg_idx_e'(cfg_idx_i))
        CFG_WHEEL_TRACK: track_q  <= cfg_data_i[11:0];
        CFG_WHEEL_BASE:  base_q   <= cfg_data_i[11:0];
        CFG_STEP_RELOAD: reload_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register.
  akfw_cmd_t cmd_q;
  logic      v0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd_q <= cmd_i.payload;
    end
  end

  // Doubled lateral offsets and magnitudes.
  logic signed [22:0] r2, offl, offr;
  logic [20:0]        ar_d;
  logic [15:0]        av_d;
  logic [21:0]        offl_q, offr_q;
  logic [20:0]        ar_q;
  logic [15:0]        av_q;
  logic [11:0]        base1_q;
  akfw_side_t         side1_q;
  logic               v1_q;

  assign r2   = {cmd_q.turn_radius[20], cmd_q.turn_radius, 1'b0};
  assign offl = r2 + $signed({11'd0, track_q});
  assign offr = r2 - $signed({11'd0, track_q});
  assign ar_d = cmd_q.turn_radius[20] ? 21'(-cmd_q.turn_radius) : cmd_q.turn_radius;
  assign av_d = cmd_q.rear_speed[15] ? 16'(-cmd_q.rear_speed) : cmd_q.rear_speed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      offl_q         <= offl[22] ? 22'(-offl) : offl[21:0];
      offr_q         <= offr[22] ? 22'(-offr) : offr[21:0];
      ar_q           <= ar_d;
      av_q           <= av_d;
      base1_q        <= base_q;
      side1_q.neg    <= cmd_q.turn_radius[20] ^ cmd_q.rear_speed[15];
      side1_q.zero   <= cmd_q.turn_radius == '0;
      side1_q.reload <= reload_q;
    end
  end

  // Speed and steering lanes for both wheels.
  logic [23:0] magl, magr;
  logic        ovfl, ovfr;
  logic [8:0]  stl, str;

  akfw_speed_lane u_speed_l (
    .clk_i (clk_i), .en_i (en), .abs_off_i (offl_q), .base_i (base1_q),
    .abs_speed_i (av_q), .abs_radius_i (ar_q), .mag_o (magl), .ovf_o (ovfl)
  );

  akfw_speed_lane u_speed_r (
    .clk_i (clk_i), .en_i (en), .abs_off_i (offr_q), .base_i (base1_q),
    .abs_speed_i (av_q), .abs_radius_i (ar_q), .mag_o (magr), .ovf_o (ovfr)
  );

  akfw_cordic #(.STEPS_PER_REV(STEPS_PER_REV)) u_cordic_l (
    .clk_i (clk_i), .en_i (en), .abs_off_i (offl_q), .base_i (base1_q),
    .steps_o (stl)
  );

  akfw_cordic #(.STEPS_PER_REV(STEPS_PER_REV)) u_cordic_r (
    .clk_i (clk_i), .en_i (en), .abs_off_i (offr_q), .base_i (base1_q),
    .steps_o (str)
  );

  // Flags, valid bits and steering results wait for the speed lanes.
  akfw_side_t  side_q [LAT_SPEED];
  logic        vld_q  [LAT_SPEED];
  logic [17:0] steer_q [STEER_ALIGN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT_SPEED; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= v1_q;
      for (int i = 1; i < LAT_SPEED; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0]  <= side1_q;
      steer_q[0] <= {stl, str};
      for (int i = 1; i < LAT_SPEED; i++) side_q[i] <= side_q[i-1];
      for (int i = 1; i < STEER_ALIGN; i++) steer_q[i] <= steer_q[i-1];
    end
  end

  // Sign, saturation and the zero-radius override.
  function automatic logic [23:0] fmt_speed(logic [23:0] mag, logic ovf,
                                            logic neg, logic zero);
    logic [23:0] res;
    if (zero) begin
      res = '0;
    end else if (neg) begin
      res = (ovf || mag > 24'h80_0000) ? 24'h80_0000 : 24'(-mag);
    end else begin
      res = (ovf || mag[23]) ? 24'h7F_FFFF : mag;
    end
    return res;
  endfunction

  akfw_side_t side_l;
  akfw_res_t  res_d;

  assign side_l = side_q[LAT_SPEED-1];

  always_comb begin
    res_d.left_speed        = fmt_speed(magl, ovfl, side_l.neg, side_l.zero);
    res_d.right_speed       = fmt_speed(magr, ovfr, side_l.neg, side_l.zero);
    res_d.left_steer_steps  = steer_q[STEER_ALIGN-1][17:9];
    res_d.right_steer_steps = steer_q[STEER_ALIGN-1][8:0];
    res_d.step_reload       = side_l.reload;
    res_d.zero_radius       = side_l.zero;
  end

  // Two-beat output buffer.
  akfw_res_t  buf_q [2];
  akfw_res_t  buf0_d, buf1_d;
  logic [1:0] cnt_q;
  logic       push, pop;
  logic [1:0] wr;

  assign en   = cnt_q != 2'd2;
  assign push = en && vld_q[LAT_SPEED-1];
  assign pop  = res_o.valid && res_o.ready;
  assign wr   = cnt_q - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // The head moves up on a pop; a new beat lands in the first free entry.
  always_comb begin
    buf0_d = buf_q[0];
    buf1_d = buf_q[1];
    if (pop) begin
      buf0_d = buf_q[1];
    end
    if (push) begin
      if (wr[0]) begin
        buf1_d = res_d;
      end else begin
        buf0_d = res_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q[0] <= buf0_d;
    buf_q[1] <= buf1_d;
  end

  assign cmd_i.ready   = en;
  assign res_o.valid   = cnt_q != '0;
  assign res_o.payload = buf_q[0];

endmodule

### tb/sv/tb_ackermann_front_wheel_kinematics.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_ackermann_front_wheel_kinematics
// Self-checking bench for the front-wheel kinematics pipeline.
// ============================================================================
// Command beats are sent with random gaps. Each accepted command is run
// through an integer model of the hub speed and steering arithmetic, and the
// expected result is queued. A monitor compares every result beat, field by
// field, with the oldest entry in the queue. The geometry is changed between
// phases, while nothing is in flight. One phase holds the result channel off
// for a long stretch so that the pipeline fills and stalls its input.
// ============================================================================
module tb_ackermann_front_wheel_kinematics;
  import akfw_pkg::*;

  localparam int unsigned STEPS_REV   = 2000;
  localparam int          DRAIN_WAIT  = 80;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          LONG_HOLD   = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  akfw_stream_if #(.payload_t(akfw_cmd_t)) cmd_if ();
  akfw_stream_if #(.payload_t(akfw_res_t)) res_if ();

  ackermann_front_wheel_kinematics #(
    .STEPS_PER_REV(STEPS_REV)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cmd_i     (cmd_if),
    .res_o     (res_if)
  );

  // Geometry as the bench believes it is programmed.
  logic [11:0] track_q;
  logic [11:0] base_q;
  logic [15:0] reload_q;

  akfw_res_t expected_results[$];
  int        error_count;
  int        cycle_count;
  bit        sender_idles;
  bit        receiver_idles;
  int        hold_request;

  // Clock.
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Integer model of the arithmetic.
  // ---------------------------------------------------------------------------

  // Floor of the square root, digit by digit.
  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned root;
    longint unsigned bitpos;
    root = 0;
    bitpos = 64'd1 << 62;
    while (bitpos > v) bitpos >>= 2;
    while (bitpos != 0) begin
      if (v >= root + bitpos) begin
        v -= root + bitpos;
        root = (root >> 1) + bitpos;
      end else begin
        root >>= 1;
      end
      bitpos >>= 2;
    end
    return root;
  endfunction

  // Steering angle of one wheel in stepper steps, from its doubled offset.
  function automatic logic [8:0] steer_steps_of(longint unsigned abs_off2);
    longint          x, y, z, xs, ys;
    longint unsigned steps;
    z = 0;
    if (base_q == 0) return '0;
    if (abs_off2 == 0) begin
      z = longint'(QUARTER_TURN);
    end else begin
      x = longint'(abs_off2 << 16);
      y = longint'(longint'(base_q) << 17);
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; z += longint'(ATAN_TURNS[i]);
        end else begin
          x -= ys; y += xs; z -= longint'(ATAN_TURNS[i]);
        end
      end
      if (z < 0) z = 0;
      if (z > longint'(QUARTER_TURN)) z = longint'(QUARTER_TURN);
    end
    steps = (longint'(z) * longint'(STEPS_REV)) >> 32;
    return (steps > 511) ? STEPS_MAX : steps[8:0];
  endfunction

  // Hub speed of one wheel, truncated toward zero and saturated.
  function automatic logic signed [23:0] hub_speed_of(longint unsigned abs_off2,
                                                      longint radius, longint speed);
    longint unsigned sq, rq, ar, av, mag;
    bit              neg;
    sq  = abs_off2 * abs_off2 + 4 * longint'(base_q) * longint'(base_q);
    rq  = sqrt_floor(sq << 20);
    ar  = (radius < 0) ? -radius : radius;
    av  = (speed < 0) ? -speed : speed;
    mag = (rq * av) / (ar << 11);
    neg = (radius < 0) != (speed < 0);
    if (neg) return (mag > 8388608) ? -24'sd8388608 : -longint'(mag);
    return (mag > 8388607) ? 24'sd8388607 : mag;
  endfunction

  function automatic akfw_res_t predict_wheels(akfw_cmd_t cmd);
    akfw_res_t       res;
    longint          radius, speed, off_l, off_r;
    longint unsigned abs_l, abs_r;
    radius = cmd.turn_radius;
    speed  = cmd.rear_speed;
    off_l  = 2 * radius + longint'(track_q);
    off_r  = 2 * radius - longint'(track_q);
    abs_l  = (off_l < 0) ? -off_l : off_l;
    abs_r  = (off_r < 0) ? -off_r : off_r;
    res.left_speed  = '0;
    res.right_speed = '0;
    if (radius != 0) begin
      res.left_speed  = hub_speed_of(abs_l, radius, speed);
      res.right_speed = hub_speed_of(abs_r, radius, speed);
    end
    res.left_steer_steps  = steer_steps_of(abs_l);
    res.right_steer_steps = steer_steps_of(abs_r);
    res.step_reload       = reload_q;
    res.zero_radius       = (radius == 0);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared drivers.
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string field, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    error_count++;
  endtask

  // Sends one command beat and queues its expected result on acceptance.
  task automatic send_command(logic signed [20:0] radius, logic signed [15:0] speed);
    akfw_cmd_t cmd;
    int        gap;
    cmd.turn_radius = radius;
    cmd.rear_speed  = speed;
    gap = sender_idles ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.payload <= cmd;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    expected_results.push_back(predict_wheels(cmd));
  endtask

  // Lowers valid and waits until every expected result has been seen.
  task automatic wait_idle();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(akfw_cfg_idx_e idx, logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // Programs all three registers; only called with the pipeline empty.
  task automatic set_geometry(logic [11:0] track, logic [11:0] base, logic [15:0] reload);
    wait_idle();
    cfg_write(CFG_WHEEL_TRACK, 16'(track));
    cfg_write(CFG_WHEEL_BASE, 16'(base));
    cfg_write(CFG_STEP_RELOAD, reload);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    track_q  = track;
    base_q   = base;
    reload_q = reload;
  endtask

  // Random command: full-range radii, small radii, radii that put one
  // wheel right on the turn centre, and zero radius.
  task automatic send_random_command();
    logic signed [20:0] radius;
    logic signed [15:0] speed;
    speed = 16'($urandom);
    case ($urandom_range(0, 5))
      0, 1: radius = 21'($urandom);
      2, 3: radius = 21'($signed($urandom_range(0, 8000)) - 4000);
      4: radius = 21'(($urandom_range(0, 1) ? 1 : -1) * int'(track_q / 2)
                      + $signed($urandom_range(0, 4)) - 2);
      default: radius = '0;
    endcase
    send_command(radius, speed);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and result checker.
  // ---------------------------------------------------------------------------

  initial begin
    int gap;
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_request > 0) begin
        res_if.ready <= 1'b0;
        repeat (hold_request) @(posedge clk_i);
        hold_request = 0;
      end
      gap = receiver_idles ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_if.valid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    akfw_res_t got, want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.payload;
      if (expected_results.size() == 0) begin
        report_mismatch("result beats outstanding", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (got.left_speed !== want.left_speed)
          report_mismatch("left_speed", longint'(got.left_speed),
                          longint'(want.left_speed));
        if (got.right_speed !== want.right_speed)
          report_mismatch("right_speed", longint'(got.right_speed),
                          longint'(want.right_speed));
        if (got.left_steer_steps !== want.left_steer_steps)
          report_mismatch("left_steer_steps", longint'(got.left_steer_steps),
                          longint'(want.left_steer_steps));
        if (got.right_steer_steps !== want.right_steer_steps)
          report_mismatch("right_steer_steps", longint'(got.right_steer_steps),
                          longint'(want.right_steer_steps));
        if (got.step_reload !== want.step_reload)
          report_mismatch("step_reload", longint'(got.step_reload),
                          longint'(want.step_reload));
        if (got.zero_radius !== want.zero_radius)
          report_mismatch("zero_radius", longint'(got.zero_radius),
                          longint'(want.zero_radius));
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Extremes of both fields, zero radius and zero offset at reset geometry.
  task automatic test_reset_geometry();
    send_command(21'sd0, 16'sd1000);
    send_command(21'sd0, -16'sd32768);
    send_command(21'sd250, 16'sd500);
    send_command(-21'sd250, 16'sd500);
    send_command(21'sd1048575, 16'sd32767);
    send_command(-21'sd1048576, -16'sd32768);
    send_command(21'sd1, 16'sd32767);
    send_command(-21'sd1, 16'sd32767);
    send_command(21'sd1, -16'sd32768);
    send_command(21'sd1000, 16'sd0);
    send_command(-21'sd600, -16'sd1);
  endtask

  // Widest and narrowest geometry, including a zero wheel base.
  task automatic test_geometry_extremes();
    set_geometry(12'd4095, 12'd4095, 16'hFFFF);
    send_command(21'sd1, -16'sd32768);
    send_command(-21'sd1, -16'sd32768);
    send_command(21'sd2047, 16'sd12345);
    send_command(-21'sd1048576, 16'sd32767);
    set_geometry(12'd1, 12'd1, 16'h0000);
    send_command(21'sd1, 16'sd32767);
    send_command(21'sd0, 16'sd7);
    send_command(21'sd1048575, -16'sd32768);
    set_geometry(12'd800, 12'd0, 16'h5A5A);
    send_command(21'sd400, 16'sd300);
    send_command(-21'sd900, 16'sd300);
    send_command(21'sd0, 16'sd300);
    set_geometry(12'd0, 12'd0, 16'hA5A5);
    send_command(21'sd0, 16'sd100);
    send_command(21'sd5, -16'sd100);
  endtask

  // The result side holds off while commands keep coming.
  task automatic test_output_stall();
    set_geometry(12'd1234, 12'd987, 16'd4321);
    hold_request = LONG_HOLD;
    sender_idles = 1'b0;
    repeat (120) send_random_command();
    sender_idles = 1'b1;
  endtask

  // Random geometry, with stretches where neither side idles.
  task automatic test_random_commands();
    for (int phase = 0; phase < 6; phase++) begin
      set_geometry(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
                   16'($urandom));
      sender_idles   = (phase != 2);
      receiver_idles = (phase != 2) && (phase != 4);
      repeat (270) send_random_command();
    end
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_WHEEL_TRACK;
    cfg_data_i     = '0;
    cmd_if.valid   = 1'b0;
    cmd_if.payload = '0;
    track_q        = TRACK_RESET;
    base_q         = BASE_RESET;
    reload_q       = RELOAD_RESET;
    error_count    = 0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    hold_request   = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_geometry();
    test_geometry_extremes();
    test_output_stall();
    test_random_commands();

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
